[src/fse_pkg.sv]
// shared constants, types and codes for the fade switch envelope
package fse_pkg;

  // field and counter widths
  localparam int TIME_BITS       = 24;
  localparam int LEVEL_FRAC_BITS = 16;
  localparam int ELAPSED_W       = 20;
  localparam int LEVEL_W         = LEVEL_FRAC_BITS + 1;
  localparam int CNT_W           = ((TIME_BITS > ELAPSED_W) ? TIME_BITS : ELAPSED_W) + 2;

  // serial divider sizing: quotient bits, multiplier operand and numerator widths
  localparam int QUOT_W = (TIME_BITS > LEVEL_FRAC_BITS) ? TIME_BITS : LEVEL_FRAC_BITS;
  localparam int MULB_W = (TIME_BITS > LEVEL_FRAC_BITS) ? TIME_BITS : LEVEL_FRAC_BITS + 1;
  localparam int PROD_W = TIME_BITS + MULB_W;
  localparam int NUM_W  = TIME_BITS + QUOT_W;
  localparam int ITER_W = $clog2(QUOT_W);

  // configuration port
  localparam int CFG_IDX_W = 2;

  localparam logic [TIME_BITS-1:0] RISE_TIME_RESET   = TIME_BITS'(250000);
  localparam logic [TIME_BITS-1:0] FALL_TIME_RESET   = TIME_BITS'(250000);
  localparam logic [TIME_BITS-1:0] MIN_SUSTAIN_RESET = '0;

  localparam logic [LEVEL_W-1:0] LEVEL_FULL = LEVEL_W'(1) << LEVEL_FRAC_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RISE_TIME,
    CFG_FALL_TIME,
    CFG_MIN_SUSTAIN,
    CFG_BLINK_MODE
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_OFF,
    PH_RISE,
    PH_HELD,
    PH_FALL
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_MUL,
    ST_DIV,
    ST_LEVEL,
    ST_DONE
  } seq_state_e;

endpackage

[src/fse_if.sv]
// request channel interfaces: tick input, level output and register writes

// tick request: elapsed time and enable
interface fse_in_if import fse_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ELAPSED_W-1:0] elapsed;
  logic                 enable;

  modport source (output valid, output elapsed, output enable, input ready);
  modport sink   (input valid, input elapsed, input enable, output ready);
endinterface

// result request: level and phase
interface fse_out_if import fse_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level;
  logic [1:0]         phase_out;

  modport source (output valid, output level, output phase_out, input ready);
  modport sink   (input valid, input level, input phase_out, output ready);
endinterface

// register write request
interface fse_cfg_if import fse_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [TIME_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[src/fade_switch_envelope_core.sv]
// fade switch envelope: attack / sustain / release level per tick
//
// One tick request (elapsed microseconds, enable) moves the envelope through off, rising,
// held and fading, and yields one result request holding the level in Q1.16 (65536 is
// full) and the phase. The block handles one tick at a time: in_i.ready is high only
// while the sequencer is idle. A tick passes an update step, a counter rescale when a
// reversal needs one, a level step, a level division when the level lies strictly inside
// a ramp, and a final step that hands the result to the output register once it is free.
// Each rescale or level division is one pass through a single shared 24x24 multiplier
// followed by a restoring divider that retires one quotient bit per cycle; both the
// level and the rescale use that same unit. A finished result sits in the output
// register while the next tick is accepted. Register writes are taken at any time
// (cfg_i.ready is always high) but should only be made while the block is idle. A ramp
// whose duration is zero reads as level zero.
module fade_switch_envelope_core import fse_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  fse_cfg_if.sink   cfg_i,
  fse_in_if.sink    in_i,
  fse_out_if.source out_o
);

  // configuration registers
  logic [TIME_BITS-1:0] rise_q, rise_d;
  logic [TIME_BITS-1:0] fall_q, fall_d;
  logic [TIME_BITS-1:0] sust_q, sust_d;
  logic                 blink_q, blink_d;

  // sequencer and envelope state
  seq_state_e              state_q, state_d;
  phase_e                  phase_q, phase_d;
  logic signed [CNT_W-1:0] cnt_q, cnt_d;
  logic                    out_valid_q, out_valid_d;

  // datapath registers
  logic [ELAPSED_W-1:0] el_q, el_d;
  logic                 en_q, en_d;
  logic [TIME_BITS-1:0] mul_a_q, mul_a_d;
  logic [MULB_W-1:0]    mul_b_q, mul_b_d;
  logic [TIME_BITS-1:0] den_q, den_d;
  logic                 for_level_q, for_level_d;
  logic [TIME_BITS-1:0] rem_q, rem_d;
  logic [QUOT_W-1:0]    num_q, num_d;
  logic [QUOT_W-1:0]    quot_q, quot_d;
  logic [ITER_W-1:0]    iter_q, iter_d;
  logic [LEVEL_W-1:0]   lvl_q, lvl_d;
  logic [LEVEL_W-1:0]   out_level_q, out_level_d;
  phase_e               out_phase_q, out_phase_d;

  // handshake outputs
  assign cfg_i.ready     = 1'b1;
  assign in_i.ready      = (state_q == ST_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.level     = out_level_q;
  assign out_o.phase_out = out_phase_q;

  // sequencer, update rules and shared multiply / divide unit
  always_comb begin
    logic signed [CNT_W-1:0]  el_s;
    logic signed [CNT_W-1:0]  base;
    logic signed [CNT_W-1:0]  sum;
    logic signed [CNT_W-1:0]  rise_s;
    logic signed [CNT_W-1:0]  fall_s;
    logic signed [CNT_W-1:0]  sust_s;
    logic signed [CNT_W-1:0]  from_s;
    logic signed [CNT_W-1:0]  dur_s;
    logic [TIME_BITS-1:0]     from_t;
    logic [TIME_BITS-1:0]     to_t;
    logic [TIME_BITS-1:0]     dur_t;
    logic                     do_rescale;
    phase_e                   new_phase;
    logic [PROD_W-1:0]        prod;
    logic [NUM_W-1:0]         num_full;
    logic [TIME_BITS:0]       trial;
    logic [TIME_BITS:0]       diff;
    logic                     ge;

    rise_d      = rise_q;
    fall_d      = fall_q;
    sust_d      = sust_q;
    blink_d     = blink_q;
    state_d     = state_q;
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    el_d        = el_q;
    en_d        = en_q;
    mul_a_d     = mul_a_q;
    mul_b_d     = mul_b_q;
    den_d       = den_q;
    for_level_d = for_level_q;
    rem_d       = rem_q;
    num_d       = num_q;
    quot_d      = quot_q;
    iter_d      = iter_q;
    lvl_d       = lvl_q;
    out_level_d = out_level_q;
    out_phase_d = out_phase_q;

    el_s   = CNT_W'(el_q);
    rise_s = CNT_W'(rise_q);
    fall_s = CNT_W'(fall_q);
    sust_s = CNT_W'(sust_q);
    base   = (phase_q == PH_OFF) ? '0 : cnt_q;
    sum    = ((phase_q == PH_OFF) || (phase_q == PH_RISE)) ? base + el_s : base - el_s;

    do_rescale = 1'b0;
    new_phase  = phase_q;
    from_t     = rise_q;
    to_t       = fall_q;
    from_s     = CNT_W'(from_t);
    dur_t      = (phase_q == PH_RISE) ? rise_q : fall_q;
    dur_s      = CNT_W'(dur_t);

    prod     = PROD_W'(mul_a_q) * PROD_W'(mul_b_q);
    num_full = prod[NUM_W-1:0];
    trial    = {rem_q, num_q[QUOT_W-1]};
    diff     = trial - {1'b0, den_q};
    ge       = (trial >= {1'b0, den_q});

    // register writes
    if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_RISE_TIME:   rise_d  = cfg_i.data;
        CFG_FALL_TIME:   fall_d  = cfg_i.data;
        CFG_MIN_SUSTAIN: sust_d  = cfg_i.data;
        CFG_BLINK_MODE:  blink_d = cfg_i.data[0];
        default:         ;
      endcase
    end

    // output register drains
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          el_d    = in_i.elapsed;
          en_d    = in_i.enable;
          state_d = ST_UPDATE;
        end
      end

      // phase transition and counter step
      ST_UPDATE: begin
        state_d = ST_LEVEL;
        unique case (phase_q)
          PH_OFF, PH_RISE: begin
            if ((phase_q == PH_RISE) && !en_q && !blink_q) begin
              do_rescale = 1'b1;
              new_phase  = PH_FALL;
              from_t     = rise_q;
              to_t       = fall_q;
            end else if (en_q || (phase_q == PH_RISE)) begin
              phase_d = PH_RISE;
              cnt_d   = sum;
              if (sum >= rise_s) begin
                cnt_d   = sust_s;
                phase_d = PH_HELD;
              end
            end
          end
          PH_HELD: begin
            if (en_q) begin
              if (cnt_q >= 0) begin
                cnt_d = sum;
              end
            end else begin
              cnt_d = sum;
              if (sum < 0) begin
                cnt_d   = fall_s;
                phase_d = PH_FALL;
              end
            end
          end
          PH_FALL: begin
            if (en_q) begin
              do_rescale = 1'b1;
              new_phase  = PH_RISE;
              from_t     = fall_q;
              to_t       = rise_q;
            end else begin
              cnt_d = sum;
              if (sum < 0) begin
                phase_d = PH_OFF;
              end
            end
          end
          default: ;
        endcase

        // reversal: clamp the counter and scale it by to / from
        if (do_rescale) begin
          from_s  = CNT_W'(from_t);
          phase_d = new_phase;
          if (from_t == '0) begin
            cnt_d = '0;
          end else begin
            if (cnt_q < 0) begin
              mul_a_d = '0;
            end else if (cnt_q > from_s) begin
              mul_a_d = from_t;
            end else begin
              mul_a_d = cnt_q[TIME_BITS-1:0];
            end
            mul_b_d     = MULB_W'(to_t);
            den_d       = from_t;
            for_level_d = 1'b0;
            state_d     = ST_MUL;
          end
        end
      end

      // level from phase and counter, saturating at both ends
      ST_LEVEL: begin
        state_d = ST_DONE;
        unique case (phase_q)
          PH_OFF:  lvl_d = '0;
          PH_HELD: lvl_d = LEVEL_FULL;
          default: begin
            if ((dur_t == '0) || (cnt_q <= 0)) begin
              lvl_d = '0;
            end else if (cnt_q >= dur_s) begin
              lvl_d = LEVEL_FULL;
            end else begin
              mul_a_d     = cnt_q[TIME_BITS-1:0];
              mul_b_d     = MULB_W'(LEVEL_FULL);
              den_d       = dur_t;
              for_level_d = 1'b1;
              state_d     = ST_MUL;
            end
          end
        endcase
      end

      // product loads the divider; its upper part is already below the divisor
      ST_MUL: begin
        rem_d   = num_full[NUM_W-1:QUOT_W];
        num_d   = num_full[QUOT_W-1:0];
        quot_d  = '0;
        iter_d  = '0;
        state_d = ST_DIV;
      end

      // one restoring division step per cycle
      ST_DIV: begin
        rem_d  = ge ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
        num_d  = num_q << 1;
        quot_d = {quot_q[QUOT_W-2:0], ge};
        iter_d = iter_q + 1'b1;
        if (iter_q == ITER_W'(QUOT_W - 1)) begin
          if (for_level_q) begin
            lvl_d   = LEVEL_W'(quot_d);
            state_d = ST_DONE;
          end else begin
            cnt_d   = CNT_W'(quot_d);
            state_d = ST_LEVEL;
          end
        end
      end

      // hand the result to the output register once it is free
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_level_d = lvl_q;
          out_phase_d = phase_q;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // control and envelope state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_q      <= RISE_TIME_RESET;
      fall_q      <= FALL_TIME_RESET;
      sust_q      <= MIN_SUSTAIN_RESET;
      blink_q     <= 1'b0;
      state_q     <= ST_IDLE;
      phase_q     <= PH_OFF;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rise_q      <= rise_d;
      fall_q      <= fall_d;
      sust_q      <= sust_d;
      blink_q     <= blink_d;
      state_q     <= state_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload and arithmetic registers
  always_ff @(posedge clk_i) begin
    el_q        <= el_d;
    en_q        <= en_d;
    mul_a_q     <= mul_a_d;
    mul_b_q     <= mul_b_d;
    den_q       <= den_d;
    for_level_q <= for_level_d;
    rem_q       <= rem_d;
    num_q       <= num_d;
    quot_q      <= quot_d;
    iter_q      <= iter_d;
    lvl_q       <= lvl_d;
    out_level_q <= out_level_d;
    out_phase_q <= out_phase_d;
  end

endmodule

[src/fse_checker.sv]
// port-level checks for the fade switch envelope, bound to the top level
module fse_checker import fse_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [LEVEL_W-1:0] level_i,
  input logic [1:0]         phase_out_i
);

  // a stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(level_i) && $stable(phase_out_i))
    else $error("result changed while stalled");

  // level never exceeds full scale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> level_i <= LEVEL_FULL)
    else $error("level above full scale");

  // held reads full, off reads zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((phase_out_i != PH_HELD) || (level_i == LEVEL_FULL)) &&
                    ((phase_out_i != PH_OFF) || (level_i == '0)))
    else $error("level does not match phase");

  // one tick in flight: busy right after taking a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second tick taken while busy");

endmodule

bind fade_switch_envelope_core fse_checker u_fse_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .level_i     (out_o.level),
  .phase_out_i (out_o.phase_out)
);

[dv/fade_switch_envelope_core_tb.sv]
// testbench for the fade switch envelope core: directed ramps, then randomized tick streams
module fade_switch_envelope_core_tb;
  import fse_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned ELAPSED_MAX = (64'd1 << ELAPSED_W) - 1;
  localparam int SETTLE_CYCLES = 64;
  localparam int RANDOM_CHUNK  = 105;
  localparam int CYCLE_LIMIT   = 1_000_000;

  typedef struct packed {
    logic [ELAPSED_W-1:0] elapsed;
    logic                 enable;
  } tick_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    phase_e             phase;
  } level_t;

  logic clk = 1'b0;
  logic rst_n;

  fse_cfg_if cfg_bus ();
  fse_in_if  in_bus ();
  fse_out_if out_bus ();

  fade_switch_envelope_core uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg_bus),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  // stimulus and scoreboard state
  tick_t  tick_queue[$];
  level_t level_queue[$];
  bit     presenting = 1'b0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  int     mismatches = 0;
  int     cycles = 0;

  // envelope predictor state and its copy of the registers
  phase_e          env_phase;
  longint          env_count;
  longint unsigned rise_t;
  longint unsigned fall_t;
  longint unsigned sustain_t;
  logic            blink_on;

  // enable run generator
  logic en_level = 1'b0;
  int   en_run = 0;

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ramp level in Q1.16, saturating, zero for a zero duration
  function automatic logic [LEVEL_W-1:0] ramp_level_of(longint c, longint unsigned dur);
    if (dur == 0 || c <= 0) return '0;
    if (longint'(dur) <= c) return LEVEL_FULL;
    return LEVEL_W'((unsigned'(c) << LEVEL_FRAC_BITS) / dur);
  endfunction

  // carry the count over to a ramp of another length
  function automatic longint rescale_count(longint c, longint unsigned from,
                                           longint unsigned to);
    longint unsigned t;
    if (from == 0) return 0;
    t = (c < 0) ? 64'd0 : unsigned'(c);
    if (t > from) t = from;
    return longint'((t * to) / from);
  endfunction

  // advance the envelope by one tick and give the resulting level
  function automatic level_t advance_envelope(logic [ELAPSED_W-1:0] el, logic en);
    longint step;
    level_t res;
    step = longint'(el);
    if (env_phase == PH_OFF && en) begin
      env_count = 0;
      env_phase = PH_RISE;
    end
    case (env_phase)
      PH_RISE: begin
        if (!en && !blink_on) begin
          env_count = rescale_count(env_count, rise_t, fall_t);
          env_phase = PH_FALL;
        end else begin
          env_count += step;
          if (env_count >= longint'(rise_t)) begin
            env_count = longint'(sustain_t);
            env_phase = PH_HELD;
          end
        end
      end
      PH_HELD: begin
        if (en) begin
          if (env_count >= 0) env_count -= step;
        end else begin
          env_count -= step;
          if (env_count < 0) begin
            env_count = longint'(fall_t);
            env_phase = PH_FALL;
          end
        end
      end
      PH_FALL: begin
        if (en) begin
          env_count = rescale_count(env_count, fall_t, rise_t);
          env_phase = PH_RISE;
        end else begin
          env_count -= step;
          if (env_count < 0) env_phase = PH_OFF;
        end
      end
      default: ;
    endcase
    case (env_phase)
      PH_RISE: res.level = ramp_level_of(env_count, rise_t);
      PH_HELD: res.level = LEVEL_FULL;
      PH_FALL: res.level = ramp_level_of(env_count, fall_t);
      default: res.level = '0;
    endcase
    res.phase = env_phase;
    return res;
  endfunction

  // tick driver: presents queued requests at the falling edge with random gaps
  always @(negedge clk) begin
    if (rst_n && !presenting && tick_queue.size() != 0 &&
        $urandom_range(0, 99) >= send_idle_pct) begin
      in_bus.elapsed <= tick_queue[0].elapsed;
      in_bus.enable  <= tick_queue[0].enable;
      in_bus.valid   <= 1'b1;
      presenting = 1'b1;
    end else if (!presenting) begin
      in_bus.valid <= 1'b0;
    end
  end

  // result receiver with random stalls
  always @(negedge clk) begin
    out_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // predict on tick acceptance, check each accepted result against the oldest prediction
  always @(posedge clk) begin
    level_t want;
    if (rst_n && in_bus.valid && in_bus.ready) begin
      level_queue.push_back(advance_envelope(in_bus.elapsed, in_bus.enable));
      void'(tick_queue.pop_front());
      presenting = 1'b0;
    end
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (level_queue.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: level %0d phase %0d", out_bus.level, out_bus.phase_out);
        mismatches++;
      end else begin
        want = level_queue.pop_front();
        if (out_bus.level !== want.level || out_bus.phase_out !== 2'(want.phase)) begin
          if (mismatches < 10)
            $display("result differs: expected level %0d phase %0d, got level %0d phase %0d",
                     want.level, want.phase, out_bus.level, out_bus.phase_out);
          mismatches++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("fade_switch_envelope_core: mismatch");
      $finish;
    end
  end

  // queue one tick request, keeping the queue shallow
  task automatic send_tick(logic [ELAPSED_W-1:0] el, logic en);
    while (tick_queue.size() >= 2) @(posedge clk);
    tick_queue.push_back('{elapsed: el, enable: en});
  endtask

  // hold off new ticks until every result is in and the block has gone quiet
  task automatic drain();
    while (tick_queue.size() != 0 || presenting || level_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one register write request
  task automatic write_reg(cfg_idx_e idx, logic [TIME_BITS-1:0] val);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    case (idx)
      CFG_RISE_TIME:   rise_t = val;
      CFG_FALL_TIME:   fall_t = val;
      CFG_MIN_SUSTAIN: sustain_t = val;
      CFG_BLINK_MODE:  blink_on = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic set_config(logic [TIME_BITS-1:0] rise, logic [TIME_BITS-1:0] fall,
                            logic [TIME_BITS-1:0] sus, logic [TIME_BITS-1:0] blink);
    write_reg(CFG_RISE_TIME, rise);
    write_reg(CFG_FALL_TIME, fall);
    write_reg(CFG_MIN_SUSTAIN, sus);
    write_reg(CFG_BLINK_MODE, blink);
  endtask

  // random duration leaning to small values, extremes included
  function automatic logic [TIME_BITS-1:0] pick_time();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return TIME_BITS'(1);
      2: return '1;
      3, 4, 5, 6: return TIME_BITS'($urandom_range(2, 4000));
      7, 8: return TIME_BITS'($urandom_range(4001, 200000));
      default: return TIME_BITS'($urandom_range(200001, 24'hFFFFFF));
    endcase
  endfunction

  // elapsed time scaled to the current durations so ramps finish in a few ticks
  function automatic logic [ELAPSED_W-1:0] pick_elapsed();
    longint unsigned span;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    span = rise_t;
    if (fall_t > span) span = fall_t;
    if (sustain_t > span) span = sustain_t;
    span = span / 3 + 1;
    if (span > ELAPSED_MAX) span = ELAPSED_MAX;
    if (roll < 5) return '0;
    if (roll < 10) return '1;
    if (roll < 20) return ELAPSED_W'($urandom());
    return ELAPSED_W'($urandom_range(0, 32'(span)));
  endfunction

  // enable held in runs, with some noise toggles
  function automatic logic pick_enable();
    if (en_run == 0) begin
      en_level = !en_level;
      en_run = $urandom_range(1, 24);
    end
    en_run--;
    if ($urandom_range(0, 99) < 12) return 1'($urandom_range(0, 1));
    return en_level;
  endfunction

  // rise, hold, fade and both reversals at reset settings, elapsed extremes
  task automatic test_ramp_basics();
    send_tick('0, 1'b0);
    send_tick('1, 1'b0);
    send_tick(20'd100000, 1'b1);
    send_tick(20'd200000, 1'b1);
    send_tick('0, 1'b0);
    send_tick(20'd1, 1'b0);
    send_tick(20'd100000, 1'b0);
    send_tick('0, 1'b1);
    send_tick(20'd50000, 1'b0);
    send_tick('1, 1'b0);
    drain();
  endtask

  // sustain countdown, which stops below zero while enable stays high
  task automatic test_min_sustain();
    set_config(24'd1000, 24'd4000, 24'd1000, 24'd0);
    send_tick(20'd2000, 1'b1);
    send_tick(20'd600, 1'b1);
    send_tick(20'd600, 1'b1);
    send_tick(20'd600, 1'b1);
    send_tick('0, 1'b0);
    drain();
  endtask

  // blink mode finishes a started rise; upper data bits of the flag are ignored
  task automatic test_blink_mode();
    set_config(24'd10000, 24'd10000, 24'd0, 24'hABCDE1);
    send_tick(20'd100, 1'b1);
    send_tick(20'd100, 1'b0);
    send_tick(20'd20000, 1'b0);
    drain();
    write_reg(CFG_BLINK_MODE, 24'hFFFFFE);
  endtask

  // zero rise and fall times: rise ends at once, zero divisors read as zero
  task automatic test_zero_durations();
    set_config(24'd0, 24'd0, 24'd0, 24'd0);
    send_tick('0, 1'b1);
    send_tick('0, 1'b0);
    send_tick(20'd1, 1'b0);
    send_tick(20'd5, 1'b1);
    send_tick('0, 1'b1);
    drain();
  endtask

  // durations shortened mid-run leave the counter past the ramp end
  task automatic test_counter_beyond_ramp();
    set_config(24'd100000, 24'd200000, 24'd0, 24'd0);
    send_tick(20'd1, 1'b0);
    send_tick(20'd60000, 1'b1);
    drain();
    write_reg(CFG_RISE_TIME, 24'd1000);
    send_tick('0, 1'b0);
    drain();
    write_reg(CFG_FALL_TIME, 24'd50000);
    send_tick('0, 1'b0);
    send_tick('1, 1'b0);
    drain();
  endtask

  // random tick stream in chunks, fresh settings between chunks
  task automatic random_phase(int s_pct, int r_pct, logic [TIME_BITS-1:0] rise,
                              logic [TIME_BITS-1:0] fall, logic [TIME_BITS-1:0] sus,
                              logic [TIME_BITS-1:0] blink);
    drain();
    send_idle_pct = s_pct;
    recv_stall_pct = r_pct;
    set_config(rise, fall, sus, blink);
    for (int chunk = 0; chunk < 4; chunk++) begin
      if (chunk != 0) begin
        drain();
        set_config(pick_time(), pick_time(), pick_time(), TIME_BITS'($urandom()));
      end
      repeat (RANDOM_CHUNK) send_tick(pick_elapsed(), pick_enable());
    end
  endtask

  task automatic test_random_no_idle();
    random_phase(0, 0, 24'd1000, 24'd3000, 24'd500, 24'd0);
  endtask

  task automatic test_random_sender_idle();
    random_phase(69, 0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
  endtask

  task automatic test_random_receiver_stall();
    random_phase(0, 69, 24'd0, 24'd1, 24'd0, 24'd0);
  endtask

  task automatic test_random_both_idle();
    random_phase(18, 18, 24'd40000, 24'd7, 24'd123456, 24'd1);
  endtask

  // reset, tests in turn, final verdict
  initial begin
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.elapsed = '0;
    in_bus.enable = 1'b0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = CFG_RISE_TIME;
    cfg_bus.data = '0;
    rise_t = RISE_TIME_RESET;
    fall_t = FALL_TIME_RESET;
    sustain_t = MIN_SUSTAIN_RESET;
    blink_on = 1'b0;
    env_phase = PH_OFF;
    env_count = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_ramp_basics();
    test_min_sustain();
    test_blink_mode();
    test_zero_durations();
    test_counter_beyond_ramp();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    drain();

    if (mismatches == 0 && level_queue.size() == 0) begin
      $display("fade_switch_envelope_core: match");
    end else begin
      $display("fade_switch_envelope_core: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
src/fse_pkg.sv
src/fse_if.sv
src/fade_switch_envelope_core.sv
src/fse_checker.sv
dv/fade_switch_envelope_core_tb.sv
